FILE: rtl/alb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alb_pkg
// Shared codes, field widths and types of the affine layer block.
// ----------------------------------------------------------------------------
package alb_pkg;

   // Field widths of the command and result beats
   localparam int OpW      = 2;
   localparam int RowW     = 6;
   localparam int ColW     = 4;
   localparam int ValW     = 16;
   localparam int SumW     = 48;

   // Register widths and port sizes
   localparam int InColsW  = 7;
   localparam int OutColsW = 5;
   localparam int CsrAddrW = 4;
   localparam int CsrDataW = 32;

   // Parameter defaults
   localparam int InMaxDef     = 64;
   localparam int OutMaxDef    = 16;
   localparam int DataWidthDef = 16;

   // Operation codes
   localparam logic [OpW-1:0] OpLoadWeight = 2'd0;
   localparam logic [OpW-1:0] OpLoadBias   = 2'd1;
   localparam logic [OpW-1:0] OpData       = 2'd2;

   // Register indexes
   localparam logic [1:0] RegInCols     = 2'd0;
   localparam logic [1:0] RegOutCols    = 2'd1;
   localparam logic [1:0] RegBiasEnable = 2'd2;

   typedef struct packed {
      logic [InColsW-1:0]  in_cols;
      logic [OutColsW-1:0] out_cols;
      logic                bias_enable;
   } cfg_type;

   // One slot of work for the shared multiply-add unit
   typedef struct packed {
      logic vld;        // slot carries work
      logic out_mode;   // 1: add bias (if enabled) and emit, 0: multiply-accumulate
      logic last;       // final column of the row
   } issue_type;

endpackage
`default_nettype wire

FILE: rtl/affine_layer_matrix_bias.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// affine_layer_matrix_bias
// Fully connected layer y = x*W (+ b), one input row at a time.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Weight and bias
// loads never raise busy. A data element keeps the block busy while the
// shared multiplier-adder walks the output columns, one column per cycle,
// and while its pipeline drains; the next element waits until busy falls.
// The last element of a row then walks the columns once more, and the sums
// leave as one beat per cycle on rsp_valid, in column order, the last one
// marked by rsp_last_of_row. Result beats cannot be held off: the receiver
// must take each in its cycle.
// ----------------------------------------------------------------------------
module affine_layer_matrix_bias #(
   parameter int IN_MAX     = alb_pkg::InMaxDef,
   parameter int OUT_MAX    = alb_pkg::OutMaxDef,
   parameter int DATA_WIDTH = alb_pkg::DataWidthDef
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic        [alb_pkg::OpW-1:0]     req_operation,
   input  wire logic        [alb_pkg::RowW-1:0]    req_weight_row,
   input  wire logic        [alb_pkg::ColW-1:0]    req_column_index,
   input  wire logic signed [alb_pkg::ValW-1:0]    req_value,
   output logic                                    rsp_valid,
   output logic             [alb_pkg::ColW-1:0]    rsp_out_column,
   output logic signed      [alb_pkg::SumW-1:0]    rsp_sum_value,
   output logic                                    rsp_last_of_row,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic        [alb_pkg::CsrAddrW-1:0] paddr,
   input  wire logic        [alb_pkg::CsrDataW-1:0] pwdata,
   output logic             [alb_pkg::CsrDataW-1:0] prdata,
   output logic                                    pready
);

   localparam int CW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
   localparam int AW = (IN_MAX * OUT_MAX > 1) ? $clog2(IN_MAX * OUT_MAX) : 1;

   alb_pkg::cfg_type   cfg;
   alb_pkg::issue_type issue;
   logic [CW-1:0]      issue_col;
   logic [AW-1:0]      issue_waddr;
   logic               accept;

   assign accept = start && !busy;

   alb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   alb_ctrl #(
      .IN_MAX  (IN_MAX),
      .OUT_MAX (OUT_MAX)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_operation (req_operation),
      .cfg           (cfg),
      .busy          (busy),
      .issue         (issue),
      .issue_col     (issue_col),
      .issue_waddr   (issue_waddr)
   );

   alb_dpath #(
      .IN_MAX     (IN_MAX),
      .OUT_MAX    (OUT_MAX),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_operation    (req_operation),
      .req_weight_row   (req_weight_row),
      .req_column_index (req_column_index),
      .req_value        (req_value),
      .bias_enable      (cfg.bias_enable),
      .issue            (issue),
      .issue_col        (issue_col),
      .issue_waddr      (issue_waddr),
      .rsp_valid        (rsp_valid),
      .rsp_out_column   (rsp_out_column),
      .rsp_sum_value    (rsp_sum_value),
      .rsp_last_of_row  (rsp_last_of_row)
   );

endmodule
`default_nettype wire

FILE: rtl/alb_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alb_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module alb_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [alb_pkg::CsrAddrW-1:0]    paddr,
   input  wire logic [alb_pkg::CsrDataW-1:0]    pwdata,
   output logic      [alb_pkg::CsrDataW-1:0]    prdata,
   output logic                                 pready,
   output alb_pkg::cfg_type                     cfg
);

   alb_pkg::cfg_type cfg_ff;
   logic [1:0]       index;

   assign index  = paddr[3:2];
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_cols     <= alb_pkg::InColsW'(1);
         cfg_ff.out_cols    <= alb_pkg::OutColsW'(1);
         cfg_ff.bias_enable <= 1'b0;
      end else if (psel && penable && pwrite && pready) begin
         unique case (index)
            alb_pkg::RegInCols:     cfg_ff.in_cols     <= pwdata[alb_pkg::InColsW-1:0];
            alb_pkg::RegOutCols:    cfg_ff.out_cols    <= pwdata[alb_pkg::OutColsW-1:0];
            alb_pkg::RegBiasEnable: cfg_ff.bias_enable <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         alb_pkg::RegInCols:     prdata = alb_pkg::CsrDataW'(cfg_ff.in_cols);
         alb_pkg::RegOutCols:    prdata = alb_pkg::CsrDataW'(cfg_ff.out_cols);
         alb_pkg::RegBiasEnable: prdata = alb_pkg::CsrDataW'(cfg_ff.bias_enable);
         default:                prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/alb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alb_ctrl
// Sequencer: walks the output columns once per data element through the
// shared multiply-add unit, then once more to emit the sums at row end.
// ----------------------------------------------------------------------------
module alb_ctrl #(
   parameter int IN_MAX  = alb_pkg::InMaxDef,
   parameter int OUT_MAX = alb_pkg::OutMaxDef,
   localparam int CW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1,
   localparam int AW = (IN_MAX * OUT_MAX > 1) ? $clog2(IN_MAX * OUT_MAX) : 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [alb_pkg::OpW-1:0]     req_operation,
   input  alb_pkg::cfg_type                 cfg,
   output logic                             busy,
   output alb_pkg::issue_type               issue,
   output logic      [CW-1:0]               issue_col,
   output logic      [AW-1:0]               issue_waddr
);

   localparam int PW  = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
   localparam int IcW = $clog2(IN_MAX + 1);
   localparam int OcW = $clog2(OUT_MAX + 1);

   typedef enum logic [2:0] {
      StIdle, StMacIssue, StMacDrain, StOutIssue, StOutDrain
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] col_ff;
   logic [PW-1:0] pos_ff;
   logic [AW-1:0] base_ff;
   logic          drain_ff;
   logic          row_end_ff;

   logic [31:0]    ic_raw, oc_raw, ic_sel, oc_sel, waddr_full, base_next;
   logic [IcW-1:0] ic_eff;
   logic [OcW-1:0] oc_eff;
   logic           col_last, row_end;
   logic           data_accept;

   // Clamp the shape registers into the stored range
   always_comb begin
      ic_raw = 32'(cfg.in_cols);
      oc_raw = 32'(cfg.out_cols);
      if (ic_raw == 32'd0)             ic_sel = 32'd1;
      else if (ic_raw > 32'(IN_MAX))   ic_sel = 32'(IN_MAX);
      else                             ic_sel = ic_raw;
      if (oc_raw == 32'd0)             oc_sel = 32'd1;
      else if (oc_raw > 32'(OUT_MAX))  oc_sel = 32'(OUT_MAX);
      else                             oc_sel = oc_raw;
      ic_eff = ic_sel[IcW-1:0];
      oc_eff = oc_sel[OcW-1:0];
   end

   assign col_last    = (32'(col_ff) + 32'd1) == 32'(oc_eff);
   assign row_end     = (32'(pos_ff) + 32'd1) >= 32'(ic_eff);
   assign data_accept = accept && (req_operation == alb_pkg::OpData);
   assign waddr_full  = 32'(base_ff) + 32'(col_ff);
   assign base_next   = 32'(base_ff) + 32'(OUT_MAX);

   assign busy           = (state_ff != StIdle);
   assign issue.vld      = (state_ff == StMacIssue) || (state_ff == StOutIssue);
   assign issue.out_mode = (state_ff == StOutIssue);
   assign issue.last     = col_last;
   assign issue_col      = col_ff;
   assign issue_waddr    = waddr_full[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= StIdle;
         col_ff     <= '0;
         pos_ff     <= '0;
         base_ff    <= '0;
         drain_ff   <= 1'b0;
         row_end_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            StIdle: begin
               if (data_accept) begin
                  state_ff   <= StMacIssue;
                  col_ff     <= '0;
                  row_end_ff <= row_end;
               end
            end
            StMacIssue: begin
               if (col_last) begin
                  col_ff   <= '0;
                  drain_ff <= 1'b0;
                  state_ff <= StMacDrain;
                  if (row_end_ff) begin
                     pos_ff  <= '0;
                     base_ff <= '0;
                  end else begin
                     pos_ff  <= pos_ff + PW'(1);
                     base_ff <= base_next[AW-1:0];
                  end
               end else begin
                  col_ff <= col_ff + CW'(1);
               end
            end
            StMacDrain: begin
               // hold until the last accumulator write has landed
               if (drain_ff) begin
                  state_ff <= row_end_ff ? StOutIssue : StIdle;
               end
               drain_ff <= 1'b1;
            end
            StOutIssue: begin
               if (col_last) begin
                  col_ff   <= '0;
                  drain_ff <= 1'b0;
                  state_ff <= StOutDrain;
               end else begin
                  col_ff <= col_ff + CW'(1);
               end
            end
            StOutDrain: begin
               if (drain_ff) begin
                  state_ff <= StIdle;
               end
               drain_ff <= 1'b1;
            end
            default: state_ff <= StIdle;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_data_starts_walk: assert property (@(posedge clock) disable iff (reset)
      data_accept |=> (state_ff == StMacIssue) && (col_ff == '0))
      else $error("data beat did not start a column walk at column zero");

   a_out_only_at_row_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StOutIssue) |-> row_end_ff)
      else $error("emitting sums for a row that has not ended");

   a_drain_two_cycles: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StMacDrain) && !drain_ff |=> (state_ff == StMacDrain))
      else $error("multiply-accumulate drain cut short");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      issue.vld |-> (32'(col_ff) < 32'(oc_eff)))
      else $error("column counter beyond active width");
`endif

endmodule
`default_nettype wire

FILE: rtl/alb_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alb_dpath
// Weight, bias and accumulator stores around one shared multiply-add unit:
// read stage, multiply stage, add stage with accumulator write or result beat.
// ----------------------------------------------------------------------------
module alb_dpath #(
   parameter int IN_MAX     = alb_pkg::InMaxDef,
   parameter int OUT_MAX    = alb_pkg::OutMaxDef,
   parameter int DATA_WIDTH = alb_pkg::DataWidthDef,
   localparam int CW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1,
   localparam int AW = (IN_MAX * OUT_MAX > 1) ? $clog2(IN_MAX * OUT_MAX) : 1
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               accept,
   input  wire logic        [alb_pkg::OpW-1:0]     req_operation,
   input  wire logic        [alb_pkg::RowW-1:0]    req_weight_row,
   input  wire logic        [alb_pkg::ColW-1:0]    req_column_index,
   input  wire logic signed [alb_pkg::ValW-1:0]    req_value,
   input  wire logic                               bias_enable,
   input  alb_pkg::issue_type                      issue,
   input  wire logic        [CW-1:0]               issue_col,
   input  wire logic        [AW-1:0]               issue_waddr,
   output logic                                    rsp_valid,
   output logic             [alb_pkg::ColW-1:0]    rsp_out_column,
   output logic signed      [alb_pkg::SumW-1:0]    rsp_sum_value,
   output logic                                    rsp_last_of_row
);

   localparam int DW    = DATA_WIDTH;
   localparam int SW    = alb_pkg::SumW;
   localparam int PRODW = 2 * DATA_WIDTH;
   localparam int DEPTH = IN_MAX * OUT_MAX;

   logic [DW-1:0] weight_mem [DEPTH];
   logic [DW-1:0] bias_mem   [OUT_MAX];
   logic [SW-1:0] acc_mem    [OUT_MAX];
   logic [OUT_MAX-1:0] acc_valid_ff;

   logic [DW-1:0] x_ff;
   logic [DW-1:0] w_rd_ff, b_rd_ff;
   logic [SW-1:0] acc_rd_ff;
   logic          accv_ff;

   alb_pkg::issue_type s1_ff, s2_ff;
   logic [CW-1:0]      s1_col_ff, s2_col_ff;
   logic [SW-1:0]      acc2_ff, opnd_ff, opnd_in;

   logic [31:0]             val32, wr_addr32, col32, out_col32;
   logic [DW-1:0]           val_dw;
   logic signed [PRODW-1:0] prod;
   logic signed [63:0]      prod64;
   logic [SW-1:0]           sum;
   logic                    ld_weight, ld_bias;

   // Loads keep the low bits of the value; wider stores see it zero-extended
   assign val32     = 32'($unsigned(req_value));
   assign val_dw    = val32[DW-1:0];
   assign col32     = 32'(req_column_index);
   assign wr_addr32 = 32'(req_weight_row) * 32'(OUT_MAX) + col32;
   assign ld_weight = accept && (req_operation == alb_pkg::OpLoadWeight)
                      && (32'(req_weight_row) < 32'(IN_MAX)) && (col32 < 32'(OUT_MAX));
   assign ld_bias   = accept && (req_operation == alb_pkg::OpLoadBias)
                      && (col32 < 32'(OUT_MAX));

   // Stores and read stage
   always_ff @(posedge clock) begin
      if (ld_weight) begin
         weight_mem[wr_addr32[AW-1:0]] <= val_dw;
      end
      if (ld_bias) begin
         bias_mem[col32[CW-1:0]] <= val_dw;
      end
      if (accept && (req_operation == alb_pkg::OpData)) begin
         x_ff <= val_dw;
      end
      w_rd_ff   <= weight_mem[issue_waddr];
      b_rd_ff   <= bias_mem[issue_col];
      acc_rd_ff <= acc_mem[issue_col];
      accv_ff   <= acc_valid_ff[issue_col];
      s1_col_ff <= issue_col;
      if (s2_ff.vld && !s2_ff.out_mode) begin
         acc_mem[s2_col_ff] <= sum;
      end
   end

   // Shared unit: multiplier, then one adder for accumulate and bias
   assign prod   = $signed(x_ff) * $signed(w_rd_ff);
   assign prod64 = 64'(prod);

   always_comb begin
      if (!s1_ff.out_mode)  opnd_in = prod64[SW-1:0];
      else if (bias_enable) opnd_in = SW'($signed(b_rd_ff));
      else                  opnd_in = '0;
   end

   assign sum       = acc2_ff + opnd_ff;
   assign out_col32 = 32'(s2_col_ff);

   always_ff @(posedge clock) begin
      opnd_ff         <= opnd_in;
      acc2_ff         <= accv_ff ? acc_rd_ff : '0;
      s2_col_ff       <= s1_col_ff;
      rsp_out_column  <= out_col32[alb_pkg::ColW-1:0];
      rsp_sum_value   <= sum;
      rsp_last_of_row <= s2_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         s2_ff        <= '0;
         rsp_valid    <= 1'b0;
         acc_valid_ff <= '0;
      end else begin
         s1_ff     <= issue;
         s2_ff     <= s1_ff;
         rsp_valid <= s2_ff.vld && s2_ff.out_mode;
         if (s2_ff.vld && !s2_ff.out_mode) begin
            acc_valid_ff[s2_col_ff] <= 1'b1;
         end else if (s2_ff.vld && s2_ff.out_mode && s2_ff.last) begin
            // drop all partial sums once the row is out
            acc_valid_ff <= '0;
         end
      end
   end

endmodule
`default_nettype wire
